>>> rtl/core/slta_pkg.sv
// ----------------------------------------------------------------------------
// slta_pkg: shared types and codes for the slot allocator
// Request codes, result status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slta_pkg;

  localparam int REQ_W   = 3;
  localparam int IDX_W   = 6;
  localparam int EXT_W   = 7;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_NONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN_FREE,
    ST_SCAN_USED,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_out;
    logic             hit;
    status_t          status;
    logic [EXT_W-1:0] live_extent;
  } res_t;

endpackage

>>> rtl/core/slta_bitmap.sv
// ----------------------------------------------------------------------------
// slta_bitmap: used-bit memory
// One bit per slot, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slta_bitmap #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

>>> rtl/core/slta_ctrl.sv
// ----------------------------------------------------------------------------
// slta_ctrl: request sequencer and slot scan unit
// Walks the used-bit memory one slot per cycle with a shared pointer and
// compare, and keeps the high-water and freed counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slta_ctrl import slta_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  logic [REQ_W-1:0] req_type,
  input  logic [IDX_W-1:0] req_index,
  output logic             req_ready,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic             wr_bit,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic             rd_bit
);

  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    hw_r, hw_nxt;
  logic [CW-1:0]    freed_r, freed_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic             is_remove_r, is_remove_nxt;
  logic [IDX_W-1:0] res_slot_r, res_slot_nxt;
  logic             res_hit_r, res_hit_nxt;
  status_t          res_stat_r, res_stat_nxt;

  logic [CW-1:0]    ptr_inc;
  logic             scan_last;
  logic             idx_in_range;

  assign ptr_inc      = CW'(ptr_r) + CW'(1);
  assign scan_last    = (ptr_inc >= hw_r);
  assign idx_in_range = (XW'(req_index) < XW'(hw_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hw_r    <= '0;
      freed_r <= '0;
    end else begin
      state_r <= state_nxt;
      hw_r    <= hw_nxt;
      freed_r <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    is_remove_r <= is_remove_nxt;
    res_slot_r  <= res_slot_nxt;
    res_hit_r   <= res_hit_nxt;
    res_stat_r  <= res_stat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    hw_nxt        = hw_r;
    freed_nxt     = freed_r;
    ptr_nxt       = ptr_r;
    is_remove_nxt = is_remove_r;
    res_slot_nxt  = res_slot_r;
    res_hit_nxt   = res_hit_r;
    res_stat_nxt  = res_stat_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_bit        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          res_slot_nxt  = '0;
          res_hit_nxt   = 1'b0;
          res_stat_nxt  = STAT_OK;
          is_remove_nxt = (req_type == REQ_REMOVE);
          unique case (req_type) inside
            REQ_ADD: begin
              if (freed_r != '0 && hw_r != '0) begin
                ptr_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = ST_SCAN_FREE;
              end else begin
                freed_nxt = '0;
                state_nxt = ST_APPEND;
              end
            end
            REQ_REMOVE, REQ_QUERY: begin
              if (idx_in_range) begin
                ptr_nxt   = AW'(req_index);
                rd_en     = 1'b1;
                rd_addr   = AW'(req_index);
                state_nxt = ST_LOOKUP;
              end else begin
                res_stat_nxt = STAT_BAD;
                state_nxt    = ST_FINISH;
              end
            end
            REQ_FIND: begin
              if (idx_in_range) begin
                ptr_nxt   = AW'(req_index);
                rd_en     = 1'b1;
                rd_addr   = AW'(req_index);
                state_nxt = ST_SCAN_USED;
              end else begin
                res_stat_nxt = STAT_BAD;
                state_nxt    = ST_FINISH;
              end
            end
            REQ_CLEAR: begin
              hw_nxt      = '0;
              freed_nxt   = '0;
              res_hit_nxt = 1'b1;
              state_nxt   = ST_FINISH;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN_FREE: begin
        if (!rd_bit) begin
          wr_en        = 1'b1;
          wr_addr      = ptr_r;
          wr_bit       = 1'b1;
          freed_nxt    = freed_r - CW'(1);
          res_slot_nxt = IDX_W'(ptr_r);
          res_hit_nxt  = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (scan_last) begin
          freed_nxt = '0;
          state_nxt = ST_APPEND;
        end else begin
          ptr_nxt = AW'(ptr_inc);
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_inc);
        end
      end

      ST_APPEND: begin
        if (hw_r >= CW'(SLOTS)) begin
          res_stat_nxt = STAT_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = AW'(hw_r);
          wr_bit       = 1'b1;
          hw_nxt       = hw_r + CW'(1);
          res_slot_nxt = IDX_W'(hw_r);
          res_hit_nxt  = 1'b1;
        end
        state_nxt = ST_FINISH;
      end

      ST_LOOKUP: begin
        if (rd_bit) begin
          res_hit_nxt = 1'b1;
          if (is_remove_r) begin
            wr_en     = 1'b1;
            wr_addr   = ptr_r;
            wr_bit    = 1'b0;
            freed_nxt = freed_r + CW'(1);
          end
        end else begin
          res_stat_nxt = STAT_BAD;
        end
        state_nxt = ST_FINISH;
      end

      ST_SCAN_USED: begin
        if (rd_bit) begin
          res_slot_nxt = IDX_W'(ptr_r);
          res_hit_nxt  = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (scan_last) begin
          res_stat_nxt = STAT_NONE;
          state_nxt    = ST_FINISH;
        end else begin
          ptr_nxt = AW'(ptr_inc);
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_inc);
        end
      end

      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign req_ready       = (state_r == ST_IDLE);
  assign res_valid       = (state_r == ST_FINISH);
  assign res.slot_out    = res_slot_r;
  assign res.hit         = res_hit_r;
  assign res.status      = res_stat_r;
  assign res.live_extent = EXT_W'(hw_r);

  a_freed_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    freed_r <= hw_r)
    else $error("freed count exceeds high-water mark");

  a_hw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CW'(SLOTS))
    else $error("high-water mark beyond pool size");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_FREE || state_r == ST_SCAN_USED || state_r == ST_LOOKUP)
    |-> (CW'(ptr_r) < hw_r))
    else $error("scan pointer at or beyond high-water mark");

  a_write_busy_only: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != ST_IDLE && state_r != ST_FINISH))
    else $error("bitmap write outside an active request");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && res_hit_r) |-> (res_stat_r == STAT_OK))
    else $error("hit reported with an error status");

endmodule

>>> rtl/core/slot_allocator_first_free_unit.sv
// ----------------------------------------------------------------------------
// slot_allocator_first_free_unit: first-fit slot allocation map
// Clear, unknown and out-of-range requests go from decode straight to the
// finish state; query and remove test the slot's used bit in a lookup state,
// and add appends at the high-water mark (or reports a full pool). Add-reuse
// and find-next scan the bitmap one slot per cycle; a reuse scan that finds
// no free slot falls to append. Requests are taken one at a time, only while
// the sequencer is idle. Reset empties the pool by zeroing the high-water mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_allocator_first_free_unit import slta_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [IDX_W-1:0] in_slot_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_slot_out,
  output logic             out_hit,
  output logic [1:0]       out_status,
  output logic [EXT_W-1:0] out_live_extent
);

  // Pointer width covers slot addresses; count width also holds SLOTS itself.
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic          req_ready;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res_r;
  logic          out_valid_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_bit;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          rd_bit;

  // Used bits above the high-water mark are never read, so the bitmap needs
  // no reset: clear and reset only zero the high-water and freed counts, and an
  // append writes its bit before any read can reach it.
  slta_bitmap #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (wr_bit),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_bit  (rd_bit)
  );

  // Sequencer: decode the transaction, walk the bitmap one slot per cycle,
  // and hold the result until the output register can take it.
  slta_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_type  (in_req_type),
    .req_index (in_slot_index),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_bit    (wr_bit),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_bit    (rd_bit)
  );

  // Take a new request only while the sequencer is idle; a finished result
  // waiting in the output register does not block the next transaction.
  assign in_stall = !req_ready;

  // Load the output register when it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while stalled; advance it only on a load.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = out_res_r.slot_out;
  assign out_hit         = out_res_r.hit;
  assign out_status      = out_res_r.status;
  assign out_live_extent = out_res_r.live_extent;

endmodule
